@@ rtl/core/sgdm_pkg.sv @@
package sgdm_pkg;

  localparam int unsigned IdxW  = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned ProdW = FracW + 1 + DataW;
  localparam int unsigned RndW  = ProdW - FracW;
  localparam int unsigned SumW  = DataW + 2;

  typedef enum logic [1:0] {
    CFG_LEARN_RATE      = 2'd0,
    CFG_MOMENTUM_FACTOR = 2'd1,
    CFG_USE_MOMENTUM    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [FracW-1:0] learn_rate;
    logic [FracW-1:0] momentum_factor;
    logic             use_momentum;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    learn_rate:      16'd655,
    momentum_factor: 16'd58982,
    use_momentum:    1'b1
  };

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] weight;
    logic signed [DataW-1:0] grad;
    logic                    fresh;
  } in_item_t;

  typedef struct packed {
    logic                    valid;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] weight;
    logic signed [DataW-1:0] dir;
    logic                    sat;
  } mom_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] weight;
    logic                    sat;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    sat;
  } sat_t;

  // round half up: floor((p + 2^15) / 2^16)
  function automatic logic signed [RndW-1:0] round_q16(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] biased;
    biased = p + ProdW'(32768);
    return biased[ProdW-1:FracW];
  endfunction

  function automatic sat_t sat32(input logic signed [SumW-1:0] v);
    sat_t r;
    if (v > SumW'(64'sd2147483647)) begin
      r.value = 32'sh7fffffff;
      r.sat   = 1'b1;
    end else if (v < -SumW'(64'sd2147483648)) begin
      r.value = 32'sh80000000;
      r.sat   = 1'b1;
    end else begin
      r.value = v[DataW-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/sgd_momentum_update_core.sv @@
// SGD-with-momentum element update. One weight/gradient pair is taken per clock unless
// the output stalls or the store is clearing; the momentum recurrence mu*m + g is closed
// in a single stage with forwarding from the stage behind it, so the same index may follow
// in the next cycle. After reset the momentum store is swept to zero, one entry per cycle;
// s_axis_tready stays low until the sweep ends. Configuration writes are taken at any time
// but must only be made while no item is in flight.
module sgd_momentum_update_core import sgdm_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [79:0]      s_axis_tdata,  // weight_index, weight_value, grad_value, zero pad
  input  logic             s_axis_tuser,  // fresh
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_index, new_weight, zero pad
  output logic             m_axis_tuser,  // saturated
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [FracW-1:0] cfg_data_i
);

  cfg_t      cfg;
  logic      pipe_en;
  logic      clear_busy;
  logic      in_accept;
  in_item_t  in_item;
  mom_item_t mom_item;
  logic      out_valid;
  out_item_t out_item;

  assign pipe_en       = !out_valid || m_axis_tready;
  assign s_axis_tready = pipe_en && !clear_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign in_item = '{
    idx:    s_axis_tdata[11:0],
    weight: s_axis_tdata[43:12],
    grad:   s_axis_tdata[75:44],
    fresh:  s_axis_tuser
  };

  sgdm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sgdm_momentum #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_momentum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .in_valid_i   (in_accept),
    .in_item_i    (in_item),
    .cfg_i        (cfg),
    .clear_busy_o (clear_busy),
    .item_o       (mom_item)
  );

  sgdm_apply u_apply (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .learn_rate_i (cfg.learn_rate),
    .item_i       (mom_item),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_item.weight, out_item.idx};
  assign m_axis_tuser  = out_item.sat;

`ifndef ASSERT_OFF
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !m_axis_tvalid)
    else $error("result presented during store clearing");

  a_empty_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_busy) |-> !mom_item.valid && !m_axis_tvalid)
    else $error("pipeline not empty at end of store clearing");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en && mom_item.valid |=> mom_item.valid)
    else $error("momentum stage item lost during stall");
`endif

endmodule

@@ rtl/core/sgdm_cfg_regs.sv @@
module sgdm_cfg_regs import sgdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [FracW-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEARN_RATE:      cfg_d.learn_rate      = cfg_data_i;
        CFG_MOMENTUM_FACTOR: cfg_d.momentum_factor = cfg_data_i;
        CFG_USE_MOMENTUM:    cfg_d.use_momentum    = cfg_data_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/sgdm_momentum.sv @@
module sgdm_momentum import sgdm_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  input  cfg_t      cfg_i,
  output logic      clear_busy_o,
  output mom_item_t item_o
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STORE_DEPTH + 1);

  logic signed [DataW-1:0] mem_q [STORE_DEPTH];
  logic signed [DataW-1:0] rd_q;

  logic            clr_busy_q;
  logic [CntW-1:0] clr_cnt_q;

  logic [AddrW+IdxW-1:0] in_idx_ext, s1_idx_ext;
  logic [AddrW-1:0]      in_addr, s1_addr;
  logic                  in_range_d;

  logic     s1_valid_q, s1_inr_q;
  in_item_t s1_item_q;

  logic                    fwd;
  logic signed [DataW-1:0] m_old;
  logic signed [ProdW-1:0] prod;
  logic signed [RndW-1:0]  m_scaled;
  logic signed [SumW-1:0]  m_sum;
  sat_t                    m_new;
  logic                    wr_en;

  logic                    s2_valid_q, s2_wrote_q;
  logic [IdxW-1:0]         s2_idx_q;
  logic signed [DataW-1:0] s2_weight_q, s2_dir_q;
  logic                    s2_sat_q;
  logic signed [DataW-1:0] dir_d;
  logic                    sat_d;

  assign in_idx_ext = (AddrW + IdxW)'(in_item_i.idx);
  assign s1_idx_ext = (AddrW + IdxW)'(s1_item_q.idx);
  assign in_addr    = in_idx_ext[AddrW-1:0];
  assign s1_addr    = s1_idx_ext[AddrW-1:0];
  assign in_range_d = 32'(in_item_i.idx) < 32'(STORE_DEPTH);

  // the item one stage ahead wrote its momentum at the edge this item read the store
  assign fwd = s2_valid_q && s2_wrote_q && (s2_idx_q == s1_item_q.idx);

  always_comb begin
    if (!s1_inr_q || s1_item_q.fresh) begin
      m_old = '0;
    end else if (fwd) begin
      m_old = s2_dir_q;
    end else begin
      m_old = rd_q;
    end
  end

  assign prod     = $signed({1'b0, cfg_i.momentum_factor}) * m_old;
  assign m_scaled = round_q16(prod);
  assign m_sum    = SumW'(m_scaled) + SumW'(s1_item_q.grad);
  assign m_new    = sat32(m_sum);

  assign wr_en = en_i && s1_valid_q && cfg_i.use_momentum && s1_inr_q;
  assign dir_d = cfg_i.use_momentum ? m_new.value : s1_item_q.grad;
  assign sat_d = cfg_i.use_momentum && m_new.sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + CntW'(1);
      if (clr_cnt_q == CntW'(STORE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q[AddrW-1:0]] <= '0;
    end else if (wr_en) begin
      mem_q[s1_addr] <= m_new.value;
    end
    if (en_i) begin
      rd_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_wrote_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s2_wrote_q <= s1_valid_q && cfg_i.use_momentum && s1_inr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_item_q   <= in_item_i;
      s1_inr_q    <= in_range_d;
      s2_idx_q    <= s1_item_q.idx;
      s2_weight_q <= s1_item_q.weight;
      s2_dir_q    <= dir_d;
      s2_sat_q    <= sat_d;
    end
  end

  assign clear_busy_o = clr_busy_q;
  assign item_o = '{
    valid:  s2_valid_q,
    idx:    s2_idx_q,
    weight: s2_weight_q,
    dir:    s2_dir_q,
    sat:    s2_sat_q
  };

endmodule

@@ rtl/core/sgdm_apply.sv @@
module sgdm_apply import sgdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [FracW-1:0] learn_rate_i,
  input  mom_item_t        item_i,
  output logic             out_valid_o,
  output out_item_t        out_item_o
);

  logic                    s3_valid_q;
  logic signed [ProdW-1:0] s3_prod_q;
  logic [IdxW-1:0]         s3_idx_q;
  logic signed [DataW-1:0] s3_weight_q;
  logic                    s3_sat_q;

  logic signed [RndW-1:0] step;
  logic signed [SumW-1:0] diff;
  sat_t                   w_new;

  logic      s4_valid_q;
  out_item_t s4_item_q;

  assign step  = round_q16(s3_prod_q);
  assign diff  = SumW'(s3_weight_q) - SumW'(step);
  assign w_new = sat32(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= item_i.valid;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_prod_q   <= $signed({1'b0, learn_rate_i}) * item_i.dir;
      s3_idx_q    <= item_i.idx;
      s3_weight_q <= item_i.weight;
      s3_sat_q    <= item_i.sat;
      s4_item_q   <= '{idx: s3_idx_q, weight: w_new.value, sat: s3_sat_q || w_new.sat};
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_item_o  = s4_item_q;

endmodule

@@ tb/tb.sv @@
module tb;
  import sgdm_pkg::*;

  localparam int unsigned StoreDepth = 4096;
  localparam logic [1:0]  CfgNoReg   = 2'd3;

  localparam logic signed [DataW-1:0] QMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] QMin = 32'sh80000000;
  localparam logic signed [DataW-1:0] QOne = 32'sh01000000;

  localparam longint LongMax = 64'sd2147483647;
  localparam longint LongMin = -64'sd2147483648;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [79:0]      s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i   = '0;
  logic [FracW-1:0] cfg_data_i    = '0;

  logic [FracW-1:0]        learn_rate_q   = CfgReset.learn_rate;
  logic [FracW-1:0]        mom_factor_q   = CfgReset.momentum_factor;
  logic                    mom_enable_q   = CfgReset.use_momentum;
  logic signed [DataW-1:0] momentum_mirror [StoreDepth];

  out_item_t pending_updates [$];
  out_item_t got_upd;
  out_item_t want_upd;
  int        err_cnt      = 0;
  int        snd_idle_pct = 0;
  int        rcv_idle_pct = 0;

  sgd_momentum_update_core #(
    .STORE_DEPTH(StoreDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < StoreDepth; i++) begin
      momentum_mirror[i] = '0;
    end
  end

  // floor((f * v + 2^15) / 2^16)
  function automatic longint scale_q16(input logic [FracW-1:0] f, input longint v);
    return (longint'({1'b0, f}) * v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip_q(input longint v, inout logic sat);
    if (v > LongMax) begin
      sat = 1'b1;
      return LongMax;
    end
    if (v < LongMin) begin
      sat = 1'b1;
      return LongMin;
    end
    return v;
  endfunction

  function automatic out_item_t predict_update(input in_item_t it);
    longint    m;
    longint    dir;
    longint    nw;
    logic      sat;
    logic      in_range;
    out_item_t r;
    sat      = 1'b0;
    in_range = 32'(it.idx) < StoreDepth;
    if (mom_enable_q) begin
      m = (it.fresh || !in_range) ? 64'sd0 : longint'(momentum_mirror[it.idx]);
      m = clip_q(scale_q16(mom_factor_q, m) + longint'(it.grad), sat);
      if (in_range) begin
        momentum_mirror[it.idx] = m[DataW-1:0];
      end
      dir = m;
    end else begin
      dir = longint'(it.grad);
    end
    nw = clip_q(longint'(it.weight) - scale_q16(learn_rate_q, dir), sat);
    r.idx    = it.idx;
    r.weight = nw[DataW-1:0];
    r.sat    = sat;
    return r;
  endfunction

  task automatic send_item(input logic [IdxW-1:0] idx, input logic signed [DataW-1:0] w,
                           input logic signed [DataW-1:0] g, input logic fresh);
    in_item_t it;
    it.idx    = idx;
    it.weight = w;
    it.grad   = g;
    it.fresh  = fresh;
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, g, w, idx};
    s_axis_tuser  <= fresh;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_updates.push_back(predict_update(it));
  endtask

  task automatic drain_updates();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [FracW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LEARN_RATE:      learn_rate_q = val;
      CFG_MOMENTUM_FACTOR: mom_factor_q = val;
      CFG_USE_MOMENTUM:    mom_enable_q = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_config();
    send_item(12'd0, 32'sd0, 32'sd0, 1'b0);
    send_item(12'd4095, QMax, QMax, 1'b1);
    send_item(12'd4095, QMin, QMin, 1'b0);
    send_item(12'd7, QOne, QOne, 1'b0);
    send_item(12'd7, QOne, QOne, 1'b0);
    send_item(12'd7, -QOne, QOne, 1'b0);
    send_item(12'd7, QOne, -QOne, 1'b1);
    send_item(12'd5, -32'sd1, -32'sd1, 1'b0);
    drain_updates();
  endtask

  task automatic test_saturation();
    write_reg(CFG_LEARN_RATE, 16'hffff);
    write_reg(CFG_MOMENTUM_FACTOR, 16'hffff);
    write_reg(CfgNoReg, 16'hffff);
    for (int i = 0; i < 3; i++) begin
      send_item(12'd9, QMin, QMax, 1'b0);
    end
    for (int i = 0; i < 3; i++) begin
      send_item(12'd10, QMax, QMin, 1'b0);
    end
    drain_updates();
  endtask

  task automatic test_plain_mode();
    write_reg(CFG_USE_MOMENTUM, 16'hfffe);
    write_reg(CFG_LEARN_RATE, 16'h0000);
    send_item(12'd9, 32'sd12345, QMax, 1'b1);
    drain_updates();
    write_reg(CFG_LEARN_RATE, 16'hffff);
    send_item(12'd11, QMax, QMin, 1'b0);
    send_item(12'd11, QMin, QMax, 1'b0);
    drain_updates();
    write_reg(CFG_LEARN_RATE, 16'h8000);
    send_item(12'd12, 32'sd0, 32'sd1, 1'b0);
    send_item(12'd12, 32'sd0, -32'sd1, 1'b0);
    drain_updates();
    // the store must have kept its contents through plain mode
    write_reg(CFG_USE_MOMENTUM, 16'h0001);
    write_reg(CFG_MOMENTUM_FACTOR, 16'h8000);
    send_item(12'd9, 32'sd0, 32'sd0, 1'b0);
    drain_updates();
  endtask

  task automatic pick_config(input int pick);
    logic [FracW-1:0] lr;
    logic [FracW-1:0] mu;
    logic [FracW-1:0] en;
    case (pick)
      0: begin
        lr = 16'hffff;
        mu = 16'hffff;
        en = 16'h0001;
      end
      1: begin
        lr = 16'h0000;
        mu = 16'h0000;
        en = 16'h0001;
      end
      default: begin
        lr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
        mu = 16'($urandom);
        en = ($urandom_range(3) != 0) ? 16'h0001 : 16'h0000;
      end
    endcase
    write_reg(CFG_LEARN_RATE, lr);
    write_reg(CFG_MOMENTUM_FACTOR, mu);
    write_reg(CFG_USE_MOMENTUM, en);
  endtask

  task automatic test_random_stream();
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] w;
    logic signed [DataW-1:0] g;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 28;
          rcv_idle_pct = 74;
        end
        1: begin
          snd_idle_pct = 74;
          rcv_idle_pct = 28;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        pick_config(phase * 4 + seg);
        for (int n = 0; n < 165; n++) begin
          idx = ($urandom_range(9) < 6) ? 12'($urandom_range(15)) : 12'($urandom);
          w   = $urandom;
          g   = $urandom;
          if ($urandom_range(1) == 0) w = w >>> $urandom_range(31);
          if ($urandom_range(1) == 0) g = g >>> $urandom_range(31);
          send_item(idx, w, g, $urandom_range(99) < 8);
        end
        drain_updates();
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_upd.idx    = m_axis_tdata[IdxW-1:0];
      got_upd.weight = m_axis_tdata[IdxW+DataW-1:IdxW];
      got_upd.sat    = m_axis_tuser;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result idx %0d weight %h sat %b", $time,
                 got_upd.idx, got_upd.weight, got_upd.sat);
        err_cnt++;
      end else begin
        want_upd = pending_updates.pop_front();
        if (got_upd.idx !== want_upd.idx) begin
          $display("%0t: out_index expected %0d actual %0d", $time, want_upd.idx,
                   got_upd.idx);
          err_cnt++;
        end
        if (got_upd.weight !== want_upd.weight) begin
          $display("%0t: new_weight expected %h actual %h", $time, want_upd.weight,
                   got_upd.weight);
          err_cnt++;
        end
        if (got_upd.sat !== want_upd.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want_upd.sat,
                   got_upd.sat);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_saturation();
    test_plain_mode();
    test_random_stream();
    drain_updates();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
